// File: rtl/core/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
// Holds the request and response payloads and the per-cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic [1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_BACK  = 2'd1,
		FUNC_POP_FRONT  = 2'd2,
		FUNC_POP_BACK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef struct packed {
		func_t                     func;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  popped_value;
		err_t                      error_code;
		logic        [COUNT_W-1:0] item_count;
		logic signed [WORD_W-1:0]  first_value;
		logic signed [WORD_W-1:0]  last_value;
		logic                      is_empty;
	} rsp_t;

	// Operation broadcast to every cell; already gated by the full and empty checks.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_ctl_t;

endpackage

// File: rtl/core/double_ended_queue_unit.sv
// Bounded double-ended queue built as a row of shifting cells, front entry in cell 0.
// An accepted request moves through ST_GRP, the registered tail search, then ST_FIN,
// which loads the response once the output register is free; a new request is taken
// only after that, while the previous response may still wait in the output register.
// Reset clears the entry count and the tail marks; entry contents stay undefined.
`timescale 1ns / 1ps

module double_ended_queue_unit #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  deq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output deq_pkg::rsp_t  rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GRP  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                      state_q;
	logic [CW-1:0]                   count_q;
	logic [DATA_WIDTH-1:0]           last_q;
	logic [deq_pkg::WORD_W-1:0]      popped_q;
	deq_pkg::err_t                   err_q;
	deq_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
	logic [DEPTH-1:0]                 cell_tail;
	logic [DATA_WIDTH-1:0]            value_w;
	logic [DATA_WIDTH-1:0]            last_sel;
	deq_pkg::cell_ctl_t               ctl;
	logic                             accept;
	logic                             empty;
	logic                             full;
	logic                             rsp_load;
	logic                             ok;
	deq_pkg::err_t                    err_d;
	logic [DATA_WIDTH-1:0]            popped_d;

	function automatic logic [deq_pkg::WORD_W-1:0] word_out(input logic [DATA_WIDTH-1:0] w);
		logic [63:0] ext;
		ext = 64'($signed(w));
		return ext[deq_pkg::WORD_W-1:0];
	endfunction

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign value_w   = DATA_WIDTH'($unsigned(req.value));

	always_comb begin
		ctl      = '0;
		err_d    = deq_pkg::ERR_OK;
		popped_d = '0;
		ok       = 1'b0;
		unique case (req.func)
			deq_pkg::FUNC_PUSH_FRONT: begin
				ok             = !full;
				err_d          = full ? deq_pkg::ERR_FULL : deq_pkg::ERR_OK;
				ctl.push_front = accept && ok;
			end
			deq_pkg::FUNC_PUSH_BACK: begin
				ok            = !full;
				err_d         = full ? deq_pkg::ERR_FULL : deq_pkg::ERR_OK;
				ctl.push_back = accept && ok;
			end
			deq_pkg::FUNC_POP_FRONT: begin
				ok            = !empty;
				err_d         = empty ? deq_pkg::ERR_EMPTY : deq_pkg::ERR_OK;
				popped_d      = empty ? '0 : cell_data[0];
				ctl.pop_front = accept && ok;
			end
			deq_pkg::FUNC_POP_BACK: begin
				ok           = !empty;
				err_d        = empty ? deq_pkg::ERR_EMPTY : deq_pkg::ERR_OK;
				popped_d     = empty ? '0 : last_q;
				ctl.pop_back = accept && ok;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;
		logic                  left_tail;
		logic                  right_tail;

		// Cell 0 sees an empty deque as a tail mark to its left.
		if (i == 0) begin : g_first
			assign left_data = value_w;
			assign left_tail = empty;
		end else begin : g_inner_left
			assign left_data = cell_data[i-1];
			assign left_tail = cell_tail[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = cell_data[i];
			assign right_tail = 1'b0;
		end else begin : g_inner_right
			assign right_data = cell_data[i+1];
			assign right_tail = cell_tail[i+1];
		end

		deq_cell #(
			.DW(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.value      (value_w),
			.left_data  (left_data),
			.right_data (right_data),
			.left_tail  (left_tail),
			.right_tail (right_tail),
			.data       (cell_data[i]),
			.tail       (cell_tail[i])
		);
	end

	deq_tail_sel #(
		.DEPTH (DEPTH),
		.DW    (DATA_WIDTH)
	) u_tail_sel (
		.clk       (clk),
		.en        (state_q == ST_GRP),
		.cell_data (cell_data),
		.cell_tail (cell_tail),
		.last      (last_sel)
	);

	assign rsp_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_GRP;
						if (ctl.push_front || ctl.push_back) begin
							count_q <= count_q + CW'(1);
						end else if (ctl.pop_front || ctl.pop_back) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= word_out(popped_d);
			err_q    <= err_d;
		end
		if (rsp_load) begin
			last_q                 <= last_sel;
			rsp_q.popped_value     <= popped_q;
			rsp_q.error_code       <= err_q;
			rsp_q.item_count       <= deq_pkg::COUNT_W'(count_q);
			rsp_q.first_value      <= empty ? '0 : word_out(cell_data[0]);
			rsp_q.last_value       <= empty ? '0 : word_out(last_sel);
			rsp_q.is_empty         <= empty;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_tail_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_tail))
		else $error("more than one tail mark");

	a_tail_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (cell_tail == '0))
		else $error("tail marks disagree with entry count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push_front || ctl.push_back) |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not raise the entry count");

	a_cell_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctl) && ((ctl == '0) || accept))
		else $error("cell control active without a single accepted request");

endmodule

// File: rtl/core/deq_cell.sv
// One storage cell of the deque chain: an entry and its tail mark.
// Takes data and tail marks from its neighbors, or the pushed value, when an operation is broadcast.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell #(
	parameter int unsigned DW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::cell_ctl_t  ctl,
	input  logic [DW-1:0]       value,
	input  logic [DW-1:0]       left_data,
	input  logic [DW-1:0]       right_data,
	input  logic                left_tail,
	input  logic                right_tail,
	output logic [DW-1:0]       data,
	output logic                tail
);

	logic [DW-1:0] data_q;
	logic          tail_q;

	// The cell right after the current tail is where a back push lands.
	always_ff @(posedge clk) begin
		priority if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_back && left_tail) begin
			data_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else if (ctl.push_front || ctl.push_back) begin
			tail_q <= left_tail;
		end else if (ctl.pop_front || ctl.pop_back) begin
			tail_q <= right_tail;
		end
	end

	assign data = data_q;
	assign tail = tail_q;

endmodule

// File: rtl/core/deq_tail_sel.sv
// Registered selection of the entry that carries the tail mark.
// Cells are ORed in groups of eight into registers, then the groups are combined.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module deq_tail_sel #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned DW    = 32
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [DEPTH-1:0][DW-1:0]   cell_data,
	input  logic [DEPTH-1:0]           cell_tail,
	output logic [DW-1:0]              last
);

	localparam int unsigned GRP = 8;
	localparam int unsigned NG  = (DEPTH + GRP - 1) / GRP;

	logic [NG-1:0][DW-1:0] grp_d;
	logic [NG-1:0][DW-1:0] grp_q;

	always_comb begin
		grp_d = '0;
		for (int g = 0; g < NG; g++) begin
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					grp_d[g] = grp_d[g] |
						(cell_data[g * GRP + k] & {DW{cell_tail[g * GRP + k]}});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_q <= grp_d;
		end
	end

	always_comb begin
		last = '0;
		for (int g = 0; g < NG; g++) begin
			last = last | grp_q[g];
		end
	end

endmodule
